>>> hw/rtl/lpu_pkg.sv
// Shared constants, item kinds and the 6-bit symbol coder for the LED pixel frame encoder.
package lpu_pkg;

   localparam int PINS_DEF = 8;

   localparam int PIN_BITS    = 3;
   localparam int WORD_BITS   = 32;
   localparam int CODE_BITS   = 24;
   localparam int COUNT_BITS  = 3;
   localparam int MASK_BITS   = 8;
   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 136;

   // item kinds carried in req_tuser
   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_REFRESH = 2'd2;

   // register indexes (byte address 4*index)
   localparam logic [1:0] REG_ENABLED  = 2'd0;
   localparam logic [1:0] REG_EXTENDED = 2'd1;
   localparam logic [1:0] REG_GRB      = 2'd2;
   localparam logic [1:0] REG_FILL8    = 2'd3;

   localparam logic [COUNT_BITS-1:0] BYTES_RGB  = 3'd3;
   localparam logic [COUNT_BITS-1:0] BYTES_RGBW = 3'd4;

   // symbol for one bit pair, top pair sent first
   localparam logic [5:0] SYM_TABLE [4] = '{6'b110111, 6'b000111, 6'b110100, 6'b000100};

   function automatic logic [CODE_BITS-1:0] encode_byte(input logic [7:0] b);
      logic [CODE_BITS-1:0] code;
      code = '0;
      for (int k = 0; k < 4; k++) begin
         code[6*k +: 6] = SYM_TABLE[b[7-2*k -: 2]];
      end
      return code;
   endfunction

endpackage

>>> hw/rtl/lpu_frame_fmt.sv
// Turns one stored colour word into the byte codes of a pixel frame.
module lpu_frame_fmt (
   input  logic [31:0] word,
   input  logic        grb,
   input  logic        ext,
   output logic [23:0] first_code,
   output logic [23:0] second_code,
   output logic [23:0] third_code,
   output logic [23:0] fourth_code,
   output logic [2:0]  byte_count
);
   import lpu_pkg::*;

   logic [7:0] white;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   always_comb begin
      white = word[31:24];
      red   = word[23:16];
      green = word[15:8];
      blue  = word[7:0];
      first_code  = encode_byte(grb ? green : red);
      second_code = encode_byte(grb ? red : green);
      third_code  = encode_byte(blue);
      fourth_code = ext ? encode_byte(white) : '0;
      byte_count  = ext ? BYTES_RGBW : BYTES_RGB;
   end

endmodule

>>> hw/rtl/led_pixel_uart_frame_encoder.sv
// Top level: pixel word memory, refresh sequencer, output register and register port.
//
// Items arrive on req_* (tuser = kind, tdata = pin and colour word) and are taken
// only while the sequencer is idle. A write stores the word and refreshes, a read
// returns one stored word, a forced refresh sends every pin. Results leave on rsp_*
// through one output register; tlast marks the final result of an item.
// The first result of a read is registered in the output register from S_SEND; a
// write or forced refresh first passes S_FETCH and then S_SEND. A refresh visits
// S_FETCH once per visited pin, where the single read port of the word memory
// fetches that pin's word, and S_SEND once per frame, eight frames per pin under
// fill8. S_SEND waits while the output register is full and not taken, and a new
// item is taken only after the sequencer is back in S_IDLE.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; an idle block still takes a new item while a result waits.
// Reset clears the sequencer, the output valid, the masks and the per-pin valid
// bits, so every stored word reads as zero until written. Configuration is
// written through the csr_* port at byte address 4*index.
module led_pixel_uart_frame_encoder #(
   parameter int PINS = lpu_pkg::PINS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // tdata: pin[2:0], value[34:3], zero pad
   input  logic [lpu_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]                     req_tuser,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: read_word[31:0], frame_pin[34:32], first_byte_code[58:35],
   // second_byte_code[82:59], third_byte_code[106:83], fourth_byte_code[130:107],
   // bytes_in_frame[133:131], pin_done[134], zero pad
   output logic [lpu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: is_read_data[0]
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lpu_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [lpu_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [lpu_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                           csr_pready
);
   import lpu_pkg::*;

   localparam int PIN_W = (PINS > 1) ? $clog2(PINS) : 1;
   localparam logic [PIN_BITS:0] PIN_LIMIT = (PIN_BITS+1)'(PINS);
   localparam logic [PIN_BITS-1:0] PIN_LAST = PIN_BITS'(PINS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_SEND
   } state_type;

   // configuration
   logic [MASK_BITS-1:0] enabled_ff, extended_ff, grb_ff, fill8_ff;
   logic                 csr_write;

   // word memory
   logic [WORD_BITS-1:0] pixel_mem_ff [PINS];
   logic [PINS-1:0]      valid_ff;
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 rvalid_ff;
   logic [PIN_W-1:0]     raddr;

   // sequencer
   state_type           state_ff;
   logic [PIN_BITS-1:0] pin_ff;
   logic [2:0]          rep_ff;
   logic                force_ff;
   logic                read_mode_ff;
   logic                in_range_ff;

   // output register
   logic                  rsp_valid_ff;
   logic                  rsp_user_ff;
   logic                  rsp_last_ff;
   logic [WORD_BITS-1:0]  out_word_ff;
   logic [PIN_BITS-1:0]   out_pin_ff;
   logic [CODE_BITS-1:0]  out_c1_ff, out_c2_ff, out_c3_ff, out_c4_ff;
   logic [COUNT_BITS-1:0] out_count_ff;
   logic                  out_done_ff;

   // request fields
   logic [1:0]           req_kind;
   logic [PIN_BITS-1:0]  req_pin;
   logic [WORD_BITS-1:0] req_value;
   logic                 req_fire;
   logic                 req_in_range;

   // frame assembly
   logic [WORD_BITS-1:0]  word;
   logic [CODE_BITS-1:0]  c1, c2, c3, c4;
   logic [COUNT_BITS-1:0] count;
   logic                  out_free;
   logic                  rsp_load;
   logic                  rep_last;
   logic [PIN_BITS-1:0]   pin_next;
   logic                  more_pins;

   assign req_kind     = req_tuser;
   assign req_pin      = req_tdata[2:0];
   assign req_value    = req_tdata[34:3];
   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = ({1'b0, req_pin} < PIN_LIMIT);

   assign raddr = (state_ff == S_IDLE) ? req_pin[PIN_W-1:0] : pin_ff[PIN_W-1:0];

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= '0;
         extended_ff <= '0;
         grb_ff      <= '0;
         fill8_ff    <= '0;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_ENABLED:  enabled_ff  <= csr_pwdata[MASK_BITS-1:0];
            REG_EXTENDED: extended_ff <= csr_pwdata[MASK_BITS-1:0];
            REG_GRB:      grb_ff      <= csr_pwdata[MASK_BITS-1:0];
            REG_FILL8:    fill8_ff    <= csr_pwdata[MASK_BITS-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ENABLED:  csr_prdata = {{(CSR_DW-MASK_BITS){1'b0}}, enabled_ff};
         REG_EXTENDED: csr_prdata = {{(CSR_DW-MASK_BITS){1'b0}}, extended_ff};
         REG_GRB:      csr_prdata = {{(CSR_DW-MASK_BITS){1'b0}}, grb_ff};
         REG_FILL8:    csr_prdata = {{(CSR_DW-MASK_BITS){1'b0}}, fill8_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------- word memory ----------------
   always_ff @(posedge clock) begin
      if (req_fire && req_kind == KIND_WRITE && req_in_range) begin
         pixel_mem_ff[req_pin[PIN_W-1:0]] <= req_value;
      end
      rdata_ff <= pixel_mem_ff[raddr];
   end

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (req_fire && req_kind == KIND_WRITE && req_in_range) begin
            valid_ff[req_pin[PIN_W-1:0]] <= 1'b1;
         end
         rvalid_ff <= valid_ff[raddr];
      end
   end

   // ---------------- frame assembly ----------------
   assign word = (rvalid_ff && in_range_ff) ? rdata_ff : '0;

   lpu_frame_fmt u_fmt (
      .word        (word),
      .grb         (grb_ff[pin_ff]),
      .ext         (extended_ff[pin_ff]),
      .first_code  (c1),
      .second_code (c2),
      .third_code  (c3),
      .fourth_code (c4),
      .byte_count  (count)
   );

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_load  = (state_ff == S_SEND) && out_free;
   assign rep_last  = !fill8_ff[pin_ff] || (rep_ff == 3'd7);
   assign pin_next  = pin_ff + 3'd1;
   assign more_pins = (pin_ff != PIN_LAST) && (force_ff || enabled_ff[pin_next]);

   // ---------------- sequencer and output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pin_ff       <= '0;
         rep_ff       <= '0;
         force_ff     <= 1'b0;
         read_mode_ff <= 1'b0;
         in_range_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  rep_ff <= '0;
                  case (req_kind)
                     KIND_READ: begin
                        // word for this pin is read at this edge
                        pin_ff       <= req_pin;
                        in_range_ff  <= req_in_range;
                        read_mode_ff <= 1'b1;
                        state_ff     <= S_SEND;
                     end
                     KIND_WRITE: begin
                        pin_ff       <= '0;
                        in_range_ff  <= 1'b1;
                        read_mode_ff <= 1'b0;
                        force_ff     <= 1'b0;
                        state_ff     <= enabled_ff[0] ? S_FETCH : S_IDLE;
                     end
                     KIND_REFRESH: begin
                        pin_ff       <= '0;
                        in_range_ff  <= 1'b1;
                        read_mode_ff <= 1'b0;
                        force_ff     <= 1'b1;
                        state_ff     <= S_FETCH;
                     end
                     default: ;
                  endcase
               end
            end
            S_FETCH: begin
               rep_ff   <= '0;
               state_ff <= S_SEND;
            end
            S_SEND: begin
               if (out_free) begin
                  rsp_user_ff  <= read_mode_ff;
                  out_pin_ff   <= pin_ff;
                  if (read_mode_ff) begin
                     out_word_ff  <= word;
                     out_c1_ff    <= '0;
                     out_c2_ff    <= '0;
                     out_c3_ff    <= '0;
                     out_c4_ff    <= '0;
                     out_count_ff <= '0;
                     out_done_ff  <= 1'b0;
                     rsp_last_ff  <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     out_word_ff  <= '0;
                     out_c1_ff    <= c1;
                     out_c2_ff    <= c2;
                     out_c3_ff    <= c3;
                     out_c4_ff    <= c4;
                     out_count_ff <= count;
                     out_done_ff  <= rep_last;
                     rsp_last_ff  <= rep_last && !more_pins;
                     if (!rep_last) begin
                        rep_ff <= rep_ff + 3'd1;
                     end else if (more_pins) begin
                        pin_ff   <= pin_next;
                        state_ff <= S_FETCH;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, out_done_ff, out_count_ff, out_c4_ff, out_c3_ff, out_c2_ff,
                        out_c1_ff, out_pin_ff, out_word_ff};

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the LED pixel frame encoder: streaming items, APB masks, checks.
`timescale 1ns / 100ps

module tb_top;
   import lpu_pkg::*;

   localparam int PINS          = PINS_DEF;
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LIMIT   = 2000;
   localparam int MAX_GAP       = 6;
   localparam int MAX_REPORTS   = 10;

   // item kind that the block drops without a result
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // line symbols for one bit pair of a colour byte
   localparam logic [5:0] SYM_PAIR_00 = 6'b110111;
   localparam logic [5:0] SYM_PAIR_01 = 6'b000111;
   localparam logic [5:0] SYM_PAIR_10 = 6'b110100;
   localparam logic [5:0] SYM_PAIR_11 = 6'b000100;

   typedef struct packed {
      logic                  is_read;
      logic [WORD_BITS-1:0]  word;
      logic [PIN_BITS-1:0]   pin;
      logic [CODE_BITS-1:0]  code0;
      logic [CODE_BITS-1:0]  code1;
      logic [CODE_BITS-1:0]  code2;
      logic [CODE_BITS-1:0]  code3;
      logic [COUNT_BITS-1:0] nbytes;
      logic                  pin_done;
      logic                  last;
   } pixel_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [1:0]              req_tuser = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]       csr_paddr = '0;
   logic [CSR_DW-1:0]       csr_pwdata = '0;
   logic [CSR_DW-1:0]       csr_prdata;
   logic                    csr_pready;

   // shadow of the block's state and masks
   logic [WORD_BITS-1:0]    pixel_store [PINS];
   logic [MASK_BITS-1:0]    cfg_enabled = '0;
   logic [MASK_BITS-1:0]    cfg_extended = '0;
   logic [MASK_BITS-1:0]    cfg_grb = '0;
   logic [MASK_BITS-1:0]    cfg_fill8 = '0;

   pixel_result_type        pending_results [$];
   pixel_result_type        head_result;
   int                      mismatch_count = 0;
   bit                      steady_flow = 1'b0;

   led_pixel_uart_frame_encoder #(.PINS(PINS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [CODE_BITS-1:0] byte_symbols(input logic [7:0] color);
      logic [CODE_BITS-1:0] code;
      logic [1:0]           pair;
      code = '0;
      for (int k = 0; k < 4; k++) begin
         pair = color[7-2*k -: 2];
         case (pair)
            2'b00: code[6*k +: 6] = SYM_PAIR_00;
            2'b01: code[6*k +: 6] = SYM_PAIR_01;
            2'b10: code[6*k +: 6] = SYM_PAIR_10;
            default: code[6*k +: 6] = SYM_PAIR_11;
         endcase
      end
      return code;
   endfunction

   // work out every result an accepted item causes and queue them in order
   task automatic predict_frames(input logic [1:0] kind, input logic [PIN_BITS-1:0] pin,
                                 input logic [WORD_BITS-1:0] value);
      pixel_result_type r;
      int             produced;
      int             reps;
      logic [31:0]    w;
      logic [7:0]     lead;
      logic [7:0]     follow;
      produced = 0;
      r = '0;
      case (kind)
         KIND_READ: begin
            r.is_read = 1'b1;
            r.word    = (pin < PINS) ? pixel_store[pin] : '0;
            r.pin     = pin;
            r.last    = 1'b1;
            pending_results.push_back(r);
         end
         KIND_WRITE, KIND_REFRESH: begin
            if (kind == KIND_WRITE && pin < PINS) pixel_store[pin] = value;
            for (int p = 0; p < PINS; p++) begin
               // a normal refresh stops at the first disabled pin
               if (kind == KIND_WRITE && !cfg_enabled[p]) break;
               w      = pixel_store[p];
               lead   = cfg_grb[p] ? w[15:8] : w[23:16];
               follow = cfg_grb[p] ? w[23:16] : w[15:8];
               reps   = cfg_fill8[p] ? 8 : 1;
               for (int rep = 0; rep < reps; rep++) begin
                  r          = '0;
                  r.pin      = p[PIN_BITS-1:0];
                  r.code0    = byte_symbols(lead);
                  r.code1    = byte_symbols(follow);
                  r.code2    = byte_symbols(w[7:0]);
                  r.code3    = cfg_extended[p] ? byte_symbols(w[31:24]) : '0;
                  r.nbytes   = cfg_extended[p] ? BYTES_RGBW : BYTES_RGB;
                  r.pin_done = (rep == reps - 1);
                  pending_results.push_back(r);
                  produced++;
               end
            end
            if (produced > 0) pending_results[pending_results.size()-1].last = 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [1:0] kind, input logic [PIN_BITS-1:0] pin,
                            input logic [WORD_BITS-1:0] value);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W-WORD_BITS-PIN_BITS){1'b0}}, value, pin};
      do @(posedge clock); while (!req_tready);
      predict_frames(kind, pin, value);
   endtask

   // drop valid, wait for every owed result, then let the block go quiet
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [MASK_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {{(CSR_DW-MASK_BITS){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (index)
         REG_ENABLED:  cfg_enabled  = value;
         REG_EXTENDED: cfg_extended = value;
         REG_GRB:      cfg_grb      = value;
         default:      cfg_fill8    = value;
      endcase
   endtask

   task automatic apply_masks(input logic [7:0] enabled, input logic [7:0] extended,
                              input logic [7:0] grb, input logic [7:0] fill8);
      write_csr(REG_ENABLED, enabled);
      write_csr(REG_EXTENDED, extended);
      write_csr(REG_GRB, grb);
      write_csr(REG_FILL8, fill8);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
   endfunction

   // reset state: reads of unwritten words, write with none enabled, refresh, dropped kind
   task automatic test_reset_state_and_noise();
      send_item(KIND_READ, 3'd0, 32'h0);
      send_item(KIND_READ, 3'd6, 32'hffff_ffff);
      send_item(KIND_WRITE, 3'd0, 32'hffff_ffff);
      send_item(KIND_UNUSED, 3'd7, 32'h1234_5678);
      send_item(KIND_REFRESH, 3'd5, 32'h0);
      send_item(KIND_READ, 3'd0, 32'h0);
   endtask

   // byte order, white byte, repetition and the stop at a disabled pin
   task automatic test_frame_formats();
      settle_block();
      apply_masks(8'hff, 8'hff, 8'hff, 8'h00);
      send_item(KIND_WRITE, 3'd7, 32'h0000_0000);
      send_item(KIND_WRITE, 3'd7, 32'hffff_ffff);
      send_item(KIND_WRITE, 3'd3, 32'ha5c3_3c5a);
      send_item(KIND_READ, 3'd7, 32'h0);
      send_item(KIND_REFRESH, 3'd0, 32'h0);
      settle_block();
      apply_masks(8'h0f, 8'h55, 8'haa, 8'h81);
      send_item(KIND_WRITE, 3'd1, 32'h1b1b_1b1b);
      send_item(KIND_REFRESH, 3'd2, 32'hffff_ffff);
      send_item(KIND_WRITE, 3'd5, 32'he4e4_e4e4);
      send_item(KIND_UNUSED, 3'd0, 32'hffff_ffff);
      settle_block();
      apply_masks(8'h01, 8'h00, 8'h00, 8'hff);
      send_item(KIND_WRITE, 3'd0, 32'h00ff_00ff);
      send_item(KIND_READ, 3'd1, 32'h0);
   endtask

   task automatic test_random_traffic();
      int          sent;
      int          roll;
      logic [1:0]  kind;
      logic [7:0]  enabled;
      for (int phase = 0; phase < 6; phase++) begin
         settle_block();
         case (phase)
            0: apply_masks(8'hff, 8'hff, 8'hff, 8'hff);
            1: apply_masks(8'h00, 8'h00, 8'h00, 8'h00);
            default: begin
               // mostly a run of enabled pins from pin 0 so refreshes go deep
               enabled = ($urandom_range(0, 2) != 0) ? (8'hff >> $urandom_range(0, 7))
                                                     : 8'($urandom());
               apply_masks(enabled, 8'($urandom()), 8'($urandom()),
                           8'($urandom()) & 8'($urandom()));
            end
         endcase
         steady_flow = (phase == 2 || phase == 4);
         sent = 0;
         while (sent < 39) begin
            roll = $urandom_range(0, 99);
            kind = (roll < 50) ? KIND_WRITE :
                   (roll < 70) ? KIND_READ :
                   (roll < 92) ? KIND_REFRESH : KIND_UNUSED;
            if (steady_flow && sent == 21) steady_flow = 1'b0;
            send_item(kind, 3'($urandom_range(0, 7)), $urandom());
            if (kind != KIND_UNUSED) sent++;
            if ($urandom_range(0, 29) == 0) settle_block();
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      for (int p = 0; p < PINS; p++) pixel_store[p] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state_and_noise();
      test_frame_formats();
      test_random_traffic();
      settle_block();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // result side: stall a random number of cycles before each item, none in steady flow
   initial begin : result_sink
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result with none expected: tuser %b tdata %h", rsp_tuser, rsp_tdata);
         end else begin
            head_result = pending_results.pop_front();
            compare_field("is_read_data", 32'(head_result.is_read), 32'(rsp_tuser));
            compare_field("read_word", head_result.word, rsp_tdata[31:0]);
            compare_field("frame_pin", 32'(head_result.pin), 32'(rsp_tdata[34:32]));
            compare_field("first_byte_code", 32'(head_result.code0), 32'(rsp_tdata[58:35]));
            compare_field("second_byte_code", 32'(head_result.code1), 32'(rsp_tdata[82:59]));
            compare_field("third_byte_code", 32'(head_result.code2), 32'(rsp_tdata[106:83]));
            compare_field("fourth_byte_code", 32'(head_result.code3),
                          32'(rsp_tdata[130:107]));
            compare_field("bytes_in_frame", 32'(head_result.nbytes), 32'(rsp_tdata[133:131]));
            compare_field("pin_done", 32'(head_result.pin_done), 32'(rsp_tdata[134]));
            compare_field("last", 32'(head_result.last), 32'(rsp_tlast));
         end
      end
   end

   // end the run when neither side has moved an item for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("end of test: mismatches");
      $finish;
   end

endmodule
